### rtl/core/msr_pkg.sv
`timescale 1ns / 1ps
// msr_pkg: shared types and constants for the murmur seed ratchet.
// No dependencies; imported by msr_hash, the core and msr_chk.
package msr_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MASTER_SEED_0 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_SEED_1 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_SEED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASTER_SEED_3 = 2'd3;

	localparam logic [31:0] MM_C1   = 32'hCC9E_2D51;
	localparam logic [31:0] MM_C2   = 32'h1B87_3593;
	localparam logic [31:0] MM_C3   = 32'hE654_6B64;
	localparam logic [31:0] MM_F1   = 32'h85EB_CA6B;
	localparam logic [31:0] MM_F2   = 32'hC2B2_AE35;
	localparam logic [31:0] CHAIN_K = 32'h5BD1_E995;

	typedef struct packed {
		logic        kind;
		logic [31:0] block_index;
	} msr_req_t;

	typedef struct packed {
		logic [63:0] seed_word;
		logic [1:0]  word_index;
		logic        last;
	} msr_rsp_t;

	typedef enum logic [2:0] {
		HOP_IDLE,
		HOP_INIT,
		HOP_SCR1,
		HOP_SCR2,
		HOP_MIX,
		HOP_FIN1,
		HOP_FIN2,
		HOP_FIN3
	} hash_op_t;

	typedef struct packed {
		hash_op_t    op;
		logic        mix_en;
		logic        full;
		logic [31:0] arg;
	} hash_cmd_t;

endpackage

### rtl/core/msr_store.sv
`timescale 1ns / 1ps
// msr_store: seed store, 32-bit words, one read and one write port.
// Self-contained; cleared to zero by reset.
module msr_store #(
	parameter int NW = 8,
	parameter int AW = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [AW-1:0] rd_addr,
	output logic [31:0]   rd_data,
	input  logic          we,
	input  logic [AW-1:0] wr_addr,
	input  logic [31:0]   wr_data
);

	logic [31:0] mem_q [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NW; i++) begin
				mem_q[i] <= '0;
			end
		end else if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_addr];

endmodule

### rtl/core/msr_hash.sv
`timescale 1ns / 1ps
// msr_hash: Murmur3-32 datapath around one shared 32x32 multiplier.
// Depends on msr_pkg (hash_cmd_t, constants); driven step by step by the core.
module msr_hash import msr_pkg::*; (
	input  logic        clk,
	input  hash_cmd_t   cmd,
	output logic [31:0] hash
);

	logic [31:0] h_q;
	logic [31:0] p_q;
	logic        full_q;

	logic [31:0] hx;
	logic [31:0] hr;
	logic [31:0] mix_h;
	logic [31:0] fx;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [31:0] prod;

	assign hx    = h_q ^ p_q;
	assign hr    = {hx[18:0], hx[31:19]};
	assign mix_h = full_q ? ((hr << 2) + hr + MM_C3) : hx;
	assign fx    = h_q ^ cmd.arg;
	assign hash  = p_q ^ (p_q >> 16);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			HOP_SCR1: begin
				mul_a = cmd.arg;
				mul_b = MM_C1;
			end
			HOP_SCR2: begin
				mul_a = {p_q[16:0], p_q[31:17]};
				mul_b = MM_C2;
			end
			HOP_FIN1: begin
				mul_a = fx ^ (fx >> 16);
				mul_b = MM_F1;
			end
			HOP_FIN2: begin
				mul_a = p_q ^ (p_q >> 13);
				mul_b = MM_F2;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			HOP_INIT: h_q <= cmd.arg;
			HOP_SCR1: begin
				if (cmd.mix_en) begin
					h_q <= mix_h;
				end
				p_q <= prod;
			end
			HOP_SCR2: begin
				p_q    <= prod;
				full_q <= cmd.full;
			end
			HOP_MIX:  h_q <= mix_h;
			HOP_FIN1: p_q <= prod;
			HOP_FIN2: p_q <= prod;
			HOP_FIN3: h_q <= hash ^ cmd.arg;
			default: begin
			end
		endcase
	end

endmodule

### rtl/core/murmur_seed_ratchet_core.sv
`timescale 1ns / 1ps
// murmur_seed_ratchet_core: top level, sequencer and master seed registers.
// Depends on msr_pkg, msr_store and msr_hash.
//
// Usage:
// - cfg channel writes master_seed_0..3 (cfg_index 0..3); write only while idle.
// - A req beat with kind 0 copies the master seed into the seed store; no rsp.
//   Writes NW words (NW = ceil(SEED_BYTES/4)).
// - A req beat with kind 1 mixes block_index into the seed, runs NW Murmur3
//   passes and returns min(ceil(SEED_BYTES/8), 4) rsp beats, last on the final one.
// - Each pass runs two multiply steps per 32-bit block (S_SCR1, S_SCR2) on the one
//   shared multiplier plus the mix and finalization steps (S_MIXF, S_FIN1..3).
//   Default (32 bytes): index mix plus eight passes. Each rsp beat reads its low
//   word in S_OLO and its high word in S_OHI; a half-filled last word skips S_OHI.
// - req_ready is high only while idle; one item is in flight at a time.
// - rsp is registered; a stalled receiver holds the block in place with the
//   beat unchanged until rsp_ready.
// - Reset clears the seed store, the master registers and the sequencer.
module murmur_seed_ratchet_core import msr_pkg::*; #(
	parameter int SEED_BYTES = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  msr_req_t             req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output msr_rsp_t             rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	localparam int NW    = (SEED_BYTES + 3) / 4;
	localparam int NFULL = SEED_BYTES / 4;
	localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
	localparam int REM   = SEED_BYTES % 4;
	localparam int NOUT  = ((SEED_BYTES + 7) / 8 > 4) ? 4 : (SEED_BYTES + 7) / 8;
	localparam logic [31:0] LAST_MASK = (REM == 0) ? 32'hFFFF_FFFF :
		32'((64'd1 << (8 * REM)) - 64'd1);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_LOAD  = 12'b0000_0000_0010,
		S_XIDX  = 12'b0000_0000_0100,
		S_SCR1  = 12'b0000_0000_1000,
		S_SCR2  = 12'b0000_0001_0000,
		S_MIXF  = 12'b0000_0010_0000,
		S_FIN1  = 12'b0000_0100_0000,
		S_FIN2  = 12'b0000_1000_0000,
		S_FIN3  = 12'b0001_0000_0000,
		S_OLO   = 12'b0010_0000_0000,
		S_OHI   = 12'b0100_0000_0000,
		S_OWAIT = 12'b1000_0000_0000
	} state_t;

	function automatic logic [31:0] word_mask(input logic [AW-1:0] a);
		return (32'(a) == 32'(NW - 1)) ? LAST_MASK : 32'hFFFF_FFFF;
	endfunction

	state_t        state_q;
	logic [63:0]   master_q [4];
	logic [31:0]   bidx_q;
	logic [AW-1:0] blk_q;
	logic [AW-1:0] pass_q;
	logic [1:0]    oidx_q;
	logic [31:0]   lo_q;
	msr_rsp_t      rsp_q;

	logic [AW-1:0] rd_addr;
	logic [31:0]   rd_data;
	logic          st_we;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	hash_cmd_t     cmd;
	logic [31:0]   hash;

	logic [2:0]    lsel;
	logic [63:0]   lmaster;
	logic [31:0]   load_word;
	logic          blk_end;
	logic          pass_end;
	logic          hi_ok;
	logic          out_last;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OWAIT);
	assign rsp       = rsp_q;
	assign cfg_ready = 1'b1;

	assign lsel      = 3'(blk_q);
	assign lmaster   = master_q[lsel[2:1]];
	assign load_word = (32'(blk_q) < 32'd8) ?
		((lsel[0] ? lmaster[63:32] : lmaster[31:0]) & word_mask(blk_q)) : '0;
	assign blk_end   = (blk_q == AW'(NW - 1));
	assign pass_end  = (pass_q == AW'(NW - 1));
	assign hi_ok     = (32'({oidx_q, 1'b1}) < 32'(NW));
	assign out_last  = (oidx_q == 2'(NOUT - 1));

	msr_store #(
		.NW(NW),
		.AW(AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.we      (st_we),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	msr_hash u_hash (
		.clk  (clk),
		.cmd  (cmd),
		.hash (hash)
	);

	always_comb begin
		rd_addr    = blk_q;
		st_we      = 1'b0;
		wr_addr    = blk_q;
		wr_data    = '0;
		cmd.op     = HOP_IDLE;
		cmd.mix_en = 1'b0;
		cmd.full   = 1'b0;
		cmd.arg    = '0;
		unique case (state_q)
			S_LOAD: begin
				st_we   = 1'b1;
				wr_data = load_word;
			end
			S_XIDX: begin
				rd_addr = '0;
				wr_addr = '0;
				st_we   = 1'b1;
				wr_data = rd_data ^ (bidx_q & word_mask('0));
				cmd.op  = HOP_INIT;
				cmd.arg = bidx_q ^ CHAIN_K;
			end
			S_SCR1: begin
				cmd.op     = HOP_SCR1;
				cmd.mix_en = (blk_q != '0);
				cmd.arg    = rd_data;
			end
			S_SCR2: begin
				cmd.op   = HOP_SCR2;
				cmd.full = (32'(blk_q) < 32'(NFULL));
			end
			S_MIXF: cmd.op = HOP_MIX;
			S_FIN1: begin
				cmd.op  = HOP_FIN1;
				cmd.arg = 32'(SEED_BYTES);
			end
			S_FIN2: cmd.op = HOP_FIN2;
			S_FIN3: begin
				rd_addr = pass_q;
				wr_addr = pass_q;
				st_we   = 1'b1;
				wr_data = rd_data ^ (hash & word_mask(pass_q));
				cmd.op  = HOP_FIN3;
				cmd.arg = 32'(pass_q) + 32'd1;
			end
			S_OLO: rd_addr = AW'({oidx_q, 1'b0});
			S_OHI: rd_addr = AW'({oidx_q, 1'b1});
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				master_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MASTER_SEED_0: master_q[0] <= cfg_data;
				REG_MASTER_SEED_1: master_q[1] <= cfg_data;
				REG_MASTER_SEED_2: master_q[2] <= cfg_data;
				REG_MASTER_SEED_3: master_q[3] <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			blk_q   <= '0;
			pass_q  <= '0;
			oidx_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						blk_q   <= '0;
						pass_q  <= '0;
						state_q <= req.kind ? S_XIDX : S_LOAD;
					end
				end
				S_LOAD: begin
					if (blk_end) begin
						state_q <= S_IDLE;
					end else begin
						blk_q <= blk_q + 1'b1;
					end
				end
				S_XIDX: state_q <= S_SCR1;
				S_SCR1: state_q <= S_SCR2;
				S_SCR2: begin
					if (blk_end) begin
						state_q <= S_MIXF;
					end else begin
						blk_q   <= blk_q + 1'b1;
						state_q <= S_SCR1;
					end
				end
				S_MIXF: state_q <= S_FIN1;
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_FIN3;
				S_FIN3: begin
					if (pass_end) begin
						oidx_q  <= '0;
						state_q <= S_OLO;
					end else begin
						pass_q  <= pass_q + 1'b1;
						blk_q   <= '0;
						state_q <= S_SCR1;
					end
				end
				S_OLO: state_q <= hi_ok ? S_OHI : S_OWAIT;
				S_OHI: state_q <= S_OWAIT;
				S_OWAIT: begin
					if (rsp_ready) begin
						if (rsp_q.last) begin
							state_q <= S_IDLE;
						end else begin
							oidx_q  <= oidx_q + 1'b1;
							state_q <= S_OLO;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			bidx_q <= req.block_index;
		end
		if (state_q == S_OLO) begin
			lo_q                <= rd_data;
			rsp_q.seed_word     <= {32'd0, rd_data};
			rsp_q.word_index    <= oidx_q;
			rsp_q.last          <= out_last;
		end
		if (state_q == S_OHI) begin
			rsp_q.seed_word <= {rd_data, lo_q};
		end
	end

endmodule

### rtl/core/msr_chk.sv
`timescale 1ns / 1ps
// msr_chk: port-level checks for murmur_seed_ratchet_core, bound to the top.
// Depends on msr_pkg for the beat types.
module msr_chk import msr_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input msr_rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("rsp beat dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !rsp_valid && !req_ready)
		else $error("result or ready right after req beat");

	a_no_ready_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("req taken while rsp pending");

	a_more_words: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp.last |=> !req_ready)
		else $error("went idle before last word");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp.last |=> req_ready && !rsp_valid)
		else $error("not idle after last word");

endmodule

bind murmur_seed_ratchet_core msr_chk u_msr_chk (.*);
